>>> sv/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants for the port scan detector.
// ----------------------------------------------------------------------------
`default_nettype none

package psd_pkg;

  localparam int unsigned SOURCE_SLOTS_DEF     = 64;
  localparam int unsigned PORTS_PER_SOURCE_DEF = 32;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned PORT_W    = 16;
  localparam int unsigned PROTO_W   = 8;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned THR_W     = 16;
  localparam int unsigned WMS_W     = 27;
  localparam int unsigned NSMS_W    = 20;
  localparam int unsigned WNS_W     = WMS_W + NSMS_W;
  localparam int unsigned OUTCOME_W = 3;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [NSMS_W-1:0]  NS_PER_MS = NSMS_W'(1000000);
  localparam logic [PROTO_W-1:0] PROTO_TCP = PROTO_W'(6);

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = CFG_IDX_W'(2);

  localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(20);
  localparam logic [WMS_W-1:0] WINDOW_RST    = WMS_W'(5000);

  typedef enum logic [OUTCOME_W-1:0] {
    OC_IGNORED    = 3'd0,
    OC_NEW        = 3'd1,
    OC_TABLE_FULL = 3'd2,
    OC_RESTART    = 3'd3,
    OC_REPEAT     = 3'd4,
    OC_ADDED      = 3'd5,
    OC_ALERT      = 3'd6,
    OC_LIST_FULL  = 3'd7
  } outcome_t;

  // write command broadcast along the slot row
  typedef struct packed {
    logic              alloc;
    logic              upd;
    logic [ADDR_W-1:0] src;
    logic [TIME_W-1:0] tstamp;
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> sv/psd_ram.sv
// ----------------------------------------------------------------------------
// psd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/psd_cell.sv
// ----------------------------------------------------------------------------
// psd_cell
// One source slot: address match, port count and last update time.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned SW       = 6,
  parameter int unsigned CW       = 6
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire psd_pkg::cell_cmd_t         cmd,
  input  wire logic [SW-1:0]              cmd_idx,
  input  wire logic [CW-1:0]              cmd_cnt,
  input  wire logic [psd_pkg::ADDR_W-1:0] key,
  input  wire logic                       prev_valid,
  output logic                            valid,
  output logic                            hit,
  output logic                            free,
  output logic [CW-1:0]                   cnt,
  output logic [psd_pkg::TIME_W-1:0]      tstamp
);
  import psd_pkg::*;

  logic              valid_r;
  logic [ADDR_W-1:0] src_r;
  logic [CW-1:0]     cnt_r;
  logic [TIME_W-1:0] time_r;
  logic              sel;

  assign sel = (cmd.alloc || cmd.upd) && (cmd_idx == SW'(CELL_IDX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sel && cmd.alloc) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      if (cmd.alloc) begin
        src_r <= cmd.src;
      end
      cnt_r  <= cmd_cnt;
      time_r <= cmd.tstamp;
    end
  end

  assign valid  = valid_r;
  assign hit    = valid_r && (src_r == key);
  // slots fill in order: first empty slot after a used neighbor
  assign free   = prev_valid && !valid_r;
  assign cnt    = cnt_r;
  assign tstamp = time_r;

endmodule

`default_nettype wire

>>> sv/port_scan_detector.sv
// ----------------------------------------------------------------------------
// port_scan_detector
// Counts distinct TCP destination ports per source within an idle window
// and flags sources that reach the port threshold.
// ----------------------------------------------------------------------------
//
//   channel  | ports                         | direction
//   ---------+-------------------------------+----------
//   in       | in_valid/in_ready + header    | input
//   out      | out_valid/out_ready + result  | output
//   cfg      | cfg_valid/cfg_ready idx, data | input
//
// One packet in flight. The time from transfer to result grows with count,
// the number of ports listed for its source: the
// port list lives in a single-port-read RAM and is read one entry a cycle.
// Source lookup is combinational over the row of slot cells; ST_LOOK registers it.
// Reset (rst_n low, synchronous) empties every slot and restores registers.
// A stalled output holds its result; the next packet can be accepted and
// worked on meanwhile, finishing only once the output register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module port_scan_detector #(
  parameter int unsigned SOURCE_SLOTS     = psd_pkg::SOURCE_SLOTS_DEF,
  parameter int unsigned PORTS_PER_SOURCE = psd_pkg::PORTS_PER_SOURCE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [psd_pkg::ADDR_W-1:0]    in_source_addr,
  input  wire logic [psd_pkg::PORT_W-1:0]    in_dest_port,
  input  wire logic [psd_pkg::PROTO_W-1:0]   in_protocol_num,
  input  wire logic [psd_pkg::TIME_W-1:0]    in_time_ns,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_scan_alert,
  output logic [psd_pkg::OUTCOME_W-1:0]      out_outcome,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [psd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [psd_pkg::CFG_DAT_W-1:0] cfg_data
);
  import psd_pkg::*;

  localparam int unsigned SW    = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
  localparam int unsigned CW    = $clog2(PORTS_PER_SOURCE + 1);
  localparam int unsigned DEPTH = SOURCE_SLOTS * PORTS_PER_SOURCE;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CMPW  = THR_W + 1;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_LOOK    = 6'b000010,
    ST_RESOLVE = 6'b000100,
    ST_WIN     = 6'b001000,
    ST_SCAN    = 6'b010000,
    ST_DONE    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic              enable_r;
  logic [THR_W-1:0]  thr_r;
  logic [WMS_W-1:0]  wms_r;
  logic [WNS_W-1:0]  wns_r;

  // packet held during processing
  logic [ADDR_W-1:0]  src_r;
  logic [PORT_W-1:0]  port_r;
  logic [PROTO_W-1:0] proto_r;
  logic [TIME_W-1:0]  time_r;

  // lookup results
  logic              hit_r, hit_nxt;
  logic              full_r, full_nxt;
  logic [SW-1:0]     sel_idx_r, sel_idx_nxt;
  logic [SW-1:0]     free_idx_r, free_idx_nxt;
  logic [CW-1:0]     sel_cnt_r, sel_cnt_nxt;
  logic [TIME_W-1:0] sel_time_r, sel_time_nxt;
  logic [TIME_W-1:0] diff_r, diff_nxt;

  // port list scan
  logic [CW-1:0] rd_i_r, rd_i_nxt;
  logic          pend_r, pend_nxt;

  outcome_t res_r, res_nxt;

  logic           out_valid_r, out_valid_nxt;
  outcome_t       out_oc_r;
  logic           load_out;

  // cell row
  cell_cmd_t         cmd;
  logic [SW-1:0]     cmd_idx;
  logic [CW-1:0]     cmd_cnt;
  logic              cell_valid [SOURCE_SLOTS];
  logic              cell_hit   [SOURCE_SLOTS];
  logic              cell_free  [SOURCE_SLOTS];
  logic [CW-1:0]     cell_cnt   [SOURCE_SLOTS];
  logic [TIME_W-1:0] cell_time  [SOURCE_SLOTS];

  // port RAM
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr, base_addr;
  logic [PORT_W-1:0] ram_rdata;

  genvar g;
  generate
    for (g = 0; g < SOURCE_SLOTS; g++) begin : g_cell
      logic prev_v;
      if (g == 0) begin : g_first
        assign prev_v = 1'b1;
      end else begin : g_rest
        assign prev_v = cell_valid[g-1];
      end
      psd_cell #(
        .CELL_IDX (g),
        .SW       (SW),
        .CW       (CW)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cmd_idx    (cmd_idx),
        .cmd_cnt    (cmd_cnt),
        .key        (src_r),
        .prev_valid (prev_v),
        .valid      (cell_valid[g]),
        .hit        (cell_hit[g]),
        .free       (cell_free[g]),
        .cnt        (cell_cnt[g]),
        .tstamp     (cell_time[g])
      );
    end
  endgenerate

  psd_ram #(
    .WIDTH (PORT_W),
    .DEPTH (DEPTH)
  ) u_ports (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (port_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      thr_r    <= THRESHOLD_RST;
      wms_r    <= WINDOW_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ENABLE:    enable_r <= cfg_data[0];
        REG_THRESHOLD: thr_r    <= cfg_data[THR_W-1:0];
        REG_WINDOW:    wms_r    <= cfg_data[WMS_W-1:0];
        default:       ;
      endcase
    end
  end

  // window in ns, refreshed every cycle; the user must change config only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    wns_r <= WNS_W'(wms_r) * WNS_W'(NS_PER_MS);
  end

  // ---------------- lookup reduction over the row ----------------
  always_comb begin
    hit_nxt      = 1'b0;
    sel_idx_nxt  = '0;
    free_idx_nxt = '0;
    sel_cnt_nxt  = '0;
    sel_time_nxt = '0;
    for (int i = 0; i < SOURCE_SLOTS; i++) begin
      hit_nxt      = hit_nxt | cell_hit[i];
      sel_idx_nxt  = sel_idx_nxt  | (cell_hit[i]  ? SW'(i) : '0);
      free_idx_nxt = free_idx_nxt | (cell_free[i] ? SW'(i) : '0);
      sel_cnt_nxt  = sel_cnt_nxt  | (cell_hit[i]  ? cell_cnt[i] : '0);
      sel_time_nxt = sel_time_nxt | (cell_hit[i]  ? cell_time[i] : '0);
    end
    full_nxt = cell_valid[SOURCE_SLOTS-1];
  end

  assign base_addr = AW'(sel_idx_r) * AW'(PORTS_PER_SOURCE);
  assign ram_raddr = base_addr + AW'(rd_i_r);

  // ---------------- control ----------------
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    diff_nxt  = diff_r;
    rd_i_nxt  = rd_i_r;
    pend_nxt  = pend_r;
    cmd       = '{alloc: 1'b0, upd: 1'b0, src: src_r, tstamp: time_r};
    cmd_idx   = sel_idx_r;
    cmd_cnt   = '0;
    ram_we    = 1'b0;
    ram_waddr = base_addr;
    load_out  = 1'b0;
    in_ready  = (state_r == ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!enable_r || proto_r != PROTO_TCP) begin
          res_nxt   = OC_IGNORED;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (!hit_r) begin
          if (full_r) begin
            res_nxt = OC_TABLE_FULL;
          end else begin
            cmd.alloc = 1'b1;
            cmd_idx   = free_idx_r;
            cmd_cnt   = CW'(1);
            ram_we    = 1'b1;
            ram_waddr = AW'(free_idx_r) * AW'(PORTS_PER_SOURCE);
            res_nxt   = OC_NEW;
          end
          state_nxt = ST_DONE;
        end else begin
          diff_nxt  = time_r - sel_time_r;
          state_nxt = ST_WIN;
        end
      end
      ST_WIN: begin
        if (diff_r > TIME_W'(wns_r)) begin
          cmd.upd   = 1'b1;
          cmd_cnt   = '0;
          res_nxt   = OC_RESTART;
          state_nxt = ST_DONE;
        end else begin
          rd_i_nxt  = '0;
          pend_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pend_r && ram_rdata == port_r) begin
          res_nxt   = OC_REPEAT;
          pend_nxt  = 1'b0;
          state_nxt = ST_DONE;
        end else if (rd_i_r < sel_cnt_r) begin
          rd_i_nxt = rd_i_r + CW'(1);
          pend_nxt = 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          // list searched without a match
          if (CMPW'(sel_cnt_r) + CMPW'(1) >= CMPW'(thr_r)) begin
            res_nxt = OC_ALERT;
          end else if (sel_cnt_r < CW'(PORTS_PER_SOURCE)) begin
            cmd.upd   = 1'b1;
            cmd_cnt   = sel_cnt_r + CW'(1);
            ram_we    = 1'b1;
            ram_waddr = base_addr + AW'(sel_cnt_r);
            res_nxt   = OC_ADDED;
          end else begin
            res_nxt = OC_LIST_FULL;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      src_r   <= in_source_addr;
      port_r  <= in_dest_port;
      proto_r <= in_protocol_num;
      time_r  <= in_time_ns;
    end
    if (state_r == ST_LOOK) begin
      hit_r      <= hit_nxt;
      full_r     <= full_nxt;
      sel_idx_r  <= sel_idx_nxt;
      free_idx_r <= free_idx_nxt;
      sel_cnt_r  <= sel_cnt_nxt;
      sel_time_r <= sel_time_nxt;
    end
    diff_r <= diff_nxt;
    rd_i_r <= rd_i_nxt;
    res_r  <= res_nxt;
    if (load_out) begin
      out_oc_r <= res_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_outcome    = out_oc_r;
  assign out_scan_alert = (out_oc_r == OC_ALERT);

endmodule

`default_nettype wire

>>> tb/port_scan_detector_tb.sv
// ----------------------------------------------------------------------------
// port_scan_detector_tb
// Drives TCP and non-TCP packet headers into the detector. The scoreboard
// tracks the source slots and port lists, predicts each outcome and checks
// every result in order. Register settings vary between phases while the
// block is idle. Both channels pause at random.
// ----------------------------------------------------------------------------
`default_nettype none

module port_scan_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psd_pkg::*;

  localparam int SLOTS     = 64;
  localparam int PORT_CAP  = 32;
  localparam int POOL_SIZE = 72;

  typedef struct {
    outcome_t oc;
    bit       alert;
  } verdict_t;

  // Tracks slot state and keeps the verdicts still owed by the block.
  class scan_tracker;
    bit                  enable;
    logic [THR_W-1:0]    thresh;
    logic [WMS_W-1:0]    win_ms;
    bit                  used_slot [SLOTS];
    logic [ADDR_W-1:0]   slot_addr [SLOTS];
    int                  port_cnt  [SLOTS];
    logic [TIME_W-1:0]   stamp     [SLOTS];
    logic [PORT_W-1:0]   port_list [SLOTS][PORT_CAP];
    int                  slots_taken;
    verdict_t            owed[$];
    int                  mismatches;

    function new();
      enable      = 1'b1;
      thresh      = THRESHOLD_RST;
      win_ms      = WINDOW_RST;
      slots_taken = 0;
      mismatches  = 0;
      foreach (used_slot[i]) begin
        used_slot[i] = 1'b0;
        port_cnt[i]  = 0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        REG_ENABLE:    enable = val[0];
        REG_THRESHOLD: thresh = val[THR_W-1:0];
        REG_WINDOW:    win_ms = val[WMS_W-1:0];
        default: ;
      endcase
    endfunction

    function outcome_t classify(logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port,
                                logic [TIME_W-1:0] t);
      int s;
      int n;
      s = -1;
      for (int i = 0; i < SLOTS; i++)
        if (s < 0 && used_slot[i] && slot_addr[i] == addr) s = i;
      if (s < 0) begin
        if (slots_taken >= SLOTS) return OC_TABLE_FULL;
        s = slots_taken;
        slots_taken++;
        used_slot[s]    = 1'b1;
        slot_addr[s]    = addr;
        port_list[s][0] = port;
        port_cnt[s]     = 1;
        stamp[s]        = t;
        return OC_NEW;
      end
      // idle window measured modulo 2^64
      if (t - stamp[s] > 64'(win_ms) * 64'd1000000) begin
        port_cnt[s] = 0;
        stamp[s]    = t;
        return OC_RESTART;
      end
      n = port_cnt[s];
      for (int i = 0; i < n; i++)
        if (port_list[s][i] == port) return OC_REPEAT;
      if (n + 1 >= int'(thresh)) return OC_ALERT;
      if (n < PORT_CAP) begin
        port_list[s][n] = port;
        port_cnt[s]     = n + 1;
        stamp[s]        = t;
        return OC_ADDED;
      end
      return OC_LIST_FULL;
    endfunction

    function void note_packet(logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port,
                              logic [PROTO_W-1:0] proto, logic [TIME_W-1:0] t);
      verdict_t v;
      v.oc = OC_IGNORED;
      if (enable && proto == PROTO_TCP) v.oc = classify(addr, port, t);
      v.alert = (v.oc == OC_ALERT);
      owed.push_back(v);
    endfunction

    function void check_result(logic alert, logic [OUTCOME_W-1:0] oc);
      verdict_t v;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing owed: alert=%b outcome=%0d", $realtime, alert, oc);
        return;
      end
      v = owed.pop_front();
      if (alert !== v.alert || oc !== v.oc) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: expected alert=%b outcome=%s, got alert=%b outcome=%0d",
                   $realtime, v.alert, v.oc.name(), alert, oc);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [ADDR_W-1:0]    in_source_addr;
  logic [PORT_W-1:0]    in_dest_port;
  logic [PROTO_W-1:0]   in_protocol_num;
  logic [TIME_W-1:0]    in_time_ns;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_scan_alert;
  logic [OUTCOME_W-1:0] out_outcome;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  scan_tracker         tracker;
  logic [ADDR_W-1:0]   src_pool [POOL_SIZE];
  logic [PORT_W-1:0]   port_base;
  logic [TIME_W-1:0]   clock_ns;   // running packet time
  bit                  no_pauses;  // phase-wide: neither side idles

  port_scan_detector DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_source_addr  (in_source_addr),
    .in_dest_port    (in_dest_port),
    .in_protocol_num (in_protocol_num),
    .in_time_ns      (in_time_ns),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_scan_alert  (out_scan_alert),
    .out_outcome     (out_outcome),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("port_scan_detector_tb: errors");
    $finish;
  end

  // Pause length: mostly none or short, now and then long.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_pauses || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // Result side: out_ready alternates between runs high and stalls.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      if (pause_len() > 0) begin
        out_ready <= 1'b0;
        repeat (pause_len() + 1) @(negedge clk);
      end
    end
  end

  // Every accepted result goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_result(out_scan_alert, out_outcome);
  end

  // One packet transfer; called at a falling edge, returns at one with
  // in_valid left high so that the next packet may follow directly.
  task automatic send_packet(logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port,
                             logic [PROTO_W-1:0] proto, logic [TIME_W-1:0] t);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_source_addr  <= addr;
    in_dest_port    <= port;
    in_protocol_num <= proto;
    in_time_ns      <= t;
    do @(posedge clk); while (!in_ready);
    tracker.note_packet(addr, port, proto, t);
    @(negedge clk);
  endtask

  // Register write, only with nothing in flight.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    in_valid <= 1'b0;
    while (tracker.owed.size() != 0) @(negedge clk);
    repeat (45) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic from the first pool_lim sources of the pool.
  task automatic random_traffic(int count, int pool_lim);
    logic [ADDR_W-1:0]  addr;
    logic [PORT_W-1:0]  port;
    logic [PROTO_W-1:0] proto;
    logic [TIME_W-1:0]  win_ns;
    int                 r;
    no_pauses = ($urandom_range(0, 3) == 0);
    port_base = 16'($urandom);
    win_ns    = 64'(tracker.win_ms) * 64'd1000000;
    for (int k = 0; k < count; k++) begin
      addr = src_pool[$urandom_range(0, pool_lim - 1)];
      port = ($urandom_range(0, 9) < 8) ? port_base + 16'($urandom_range(0, 47))
                                        : 16'($urandom);
      proto = ($urandom_range(0, 99) < 85) ? PROTO_TCP : 8'($urandom_range(0, 255));
      // time steps: mostly tiny, some around the window, rarely anywhere
      r = $urandom_range(0, 99);
      if (r < 80)      clock_ns += 64'($urandom_range(0, 2000000));
      else if (r < 95) clock_ns += {$urandom, $urandom} % (2 * win_ns + 64'd1);
      else             clock_ns  = {$urandom, $urandom};
      send_packet(addr, port, proto, clock_ns);
    end
    no_pauses = 1'b0;
  endtask

  initial begin
    logic [TIME_W-1:0] t0;
    tracker         = new();
    no_pauses       = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_source_addr  = '0;
    in_dest_port    = '0;
    in_protocol_num = '0;
    in_time_ns      = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    foreach (src_pool[i]) src_pool[i] = $urandom;
    src_pool[0] = 32'h0000_0000;
    src_pool[1] = 32'hFFFF_FFFF;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, reset settings: threshold 20, window 5 s.
    t0 = {$urandom, $urandom} >> 1;
    send_packet(src_pool[0], 16'd0, PROTO_TCP, t0);             // new source
    send_packet(src_pool[0], 16'd0, PROTO_TCP, t0 + 1);         // repeat port
    send_packet(src_pool[0], 16'hFFFF, PROTO_TCP, t0 + 1);      // added
    send_packet(src_pool[0], 16'd7, 8'd17, t0 + 2);             // not TCP
    send_packet(src_pool[0], 16'd7, 8'd255, t0 + 2);
    send_packet(src_pool[0], 16'd7, 8'd0, t0 + 2);
    send_packet(src_pool[1], 16'd80, PROTO_TCP, t0);
    send_packet(src_pool[1], 16'd81, PROTO_TCP, t0 + 64'd5000000000);   // exactly window
    send_packet(src_pool[1], 16'd82, PROTO_TCP, t0 + 64'd10000000001);  // expired
    send_packet(src_pool[1], 16'd82, PROTO_TCP, t0 + 64'd10000000001);  // list restarted
    // time wraps past 2^64, then steps backwards
    send_packet(32'h8000_0001, 16'd1, PROTO_TCP, '1);
    send_packet(32'h8000_0001, 16'd2, PROTO_TCP, '0);
    send_packet(32'h8000_0001, 16'd3, PROTO_TCP, 64'hFFFF_FFFF_FFFF_FFF0);

    // Threshold 3: third distinct port alerts.
    write_reg(REG_THRESHOLD, 32'd3);
    send_packet(32'h0A00_0001, 16'd1, PROTO_TCP, t0);
    send_packet(32'h0A00_0001, 16'd2, PROTO_TCP, t0);
    send_packet(32'h0A00_0001, 16'd3, PROTO_TCP, t0);
    send_packet(32'h0A00_0001, 16'd1, PROTO_TCP, t0);
    write_reg(8'd3, 32'd1);      // unmapped indexes are dropped
    write_reg(8'hFF, 32'd0);
    clock_ns = t0;
    random_traffic(60, 8);

    // Huge threshold and window: lists fill up.
    write_reg(REG_THRESHOLD, 32'd65535);
    write_reg(REG_WINDOW, 32'd86400000);
    random_traffic(80, 6);

    // Threshold 1 and zero window.
    write_reg(REG_THRESHOLD, 32'd1);
    write_reg(REG_WINDOW, 32'd0);
    random_traffic(40, 16);

    // Detection off.
    write_reg(REG_ENABLE, 32'd0);
    random_traffic(30, 16);

    // Threshold 0 and all-ones writes, masked to the register widths.
    write_reg(REG_ENABLE, 32'hFFFF_FFFF);
    write_reg(REG_THRESHOLD, 32'hFFFF_0000);
    write_reg(REG_WINDOW, 32'hFFFF_FFFF);
    random_traffic(40, 16);

    // Back to defaults; the full pool overflows the slot table.
    write_reg(REG_THRESHOLD, 32'd20);
    write_reg(REG_WINDOW, 32'd5000);
    random_traffic(150, POOL_SIZE);

    in_valid <= 1'b0;
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.owed.size() == 0)
      $display("port_scan_detector_tb: clean");
    else
      $display("port_scan_detector_tb: errors");
    $finish;
  end

endmodule

`default_nettype wire
